FILE: rtl/core/scd_pkg.sv
// shared types, widths and pipeline stage numbers for the segment distance block
`timescale 1ns / 1ps
package scd_pkg;

  localparam int unsigned PFRAC = 30;

  localparam int unsigned ST_CODE    = 8;
  localparam int unsigned ST_DIV     = 9;
  localparam int unsigned DIV_LAT    = PFRAC + 1;
  localparam int unsigned ST_ALONG   = ST_DIV + DIV_LAT + 1;
  localparam int unsigned ST_PTS     = ST_ALONG + 2;
  localparam int unsigned ST_SUM     = ST_ALONG + 4;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned LAT        = ST_SUM + SQRT_STEPS;

  typedef logic signed [31:0]  coord_t;
  typedef logic signed [32:0]  diff_t;
  typedef logic signed [65:0]  prod_t;
  typedef logic signed [67:0]  dot_t;
  typedef logic signed [135:0] wide_t;
  typedef logic [PFRAC:0]      prm_t;

  typedef enum logic [1:0] {
    CLAMP_NONE,
    CLAMP_START,
    CLAMP_END
  } clamp_e;

endpackage

FILE: rtl/core/scd_mul.sv
// two-stage signed 68 x 68 multiplier built from four partial products
`timescale 1ns / 1ps
module scd_mul import scd_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  dot_t  a_i,
  input  dot_t  b_i,
  output wide_t p_o
);

  logic signed [34:0] al, ah, bl, bh;
  logic signed [69:0] pll_q, plh_q, phl_q, phh_q;
  logic signed [70:0] mid;
  logic [135:0]       sum;
  wide_t              p_q;

  assign al = {1'b0, a_i[33:0]};
  assign ah = {a_i[67], a_i[67:34]};
  assign bl = {1'b0, b_i[33:0]};
  assign bh = {b_i[67], b_i[67:34]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q <= al * bl;
      plh_q <= al * bh;
      phl_q <= ah * bl;
      phh_q <= ah * bh;
    end
  end

  assign mid = {plh_q[69], plh_q} + {phl_q[69], phl_q};
  assign sum = {phh_q[67:0], 68'd0}
             + {{31{mid[70]}}, mid, 34'd0}
             + {66'd0, pll_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= $signed(sum);
    end
  end

  assign p_o = p_q;

endmodule

FILE: rtl/core/scd_div.sv
// pipelined restoring divider giving the clamped segment parameter in q1.30
`timescale 1ns / 1ps
module scd_div import scd_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  wide_t n_i,
  input  wide_t dn_i,
  output prm_t  q_o
);

  logic [134:0] r_q [0:PFRAC-1];
  logic [134:0] d_q [0:PFRAC-1];
  prm_t         q_q [0:PFRAC];
  logic         n_pos, d_pos, n_ge;

  assign n_pos = !n_i[135] && (n_i != '0);
  assign d_pos = !dn_i[135] && (dn_i != '0);
  assign n_ge  = n_i >= dn_i;

  // special cases start with a zero remainder and divisor one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!(n_pos && d_pos)) begin
        r_q[0] <= '0;
        d_q[0] <= 135'd1;
        q_q[0] <= '0;
      end else if (n_ge) begin
        r_q[0] <= '0;
        d_q[0] <= 135'd1;
        q_q[0] <= prm_t'(1);
      end else begin
        r_q[0] <= n_i[134:0];
        d_q[0] <= dn_i[134:0];
        q_q[0] <= '0;
      end
    end
  end

  for (genvar i = 1; i <= PFRAC; i++) begin : g_step
    logic [135:0] r2;
    logic         ge;
    assign r2 = {r_q[i-1], 1'b0};
    assign ge = r2 >= {1'b0, d_q[i-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i] <= {q_q[i-1][PFRAC-1:0], ge};
      end
    end
    if (i < PFRAC) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[i] <= ge ? 135'(r2 - {1'b0, d_q[i-1]}) : r2[134:0];
          d_q[i] <= d_q[i-1];
        end
      end
    end
  end

  assign q_o = q_q[PFRAC];

endmodule

FILE: rtl/core/segment_closest_distance.sv
// closest points and distance between a fence segment and a path segment
// throughput: one beat per cycle; the 30-step divider and 32-step square root
// are fully pipelined, and the whole pipeline holds while an output beat waits
// reset: rst_ni clears all stage valid bits; payload registers are not reset
`timescale 1ns / 1ps
module segment_closest_distance import scd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] fence_start_x_i,
  input  logic [31:0] fence_start_y_i,
  input  logic [31:0] fence_start_z_i,
  input  logic [31:0] fence_end_x_i,
  input  logic [31:0] fence_end_y_i,
  input  logic [31:0] fence_end_z_i,
  input  logic [31:0] path_start_x_i,
  input  logic [31:0] path_start_y_i,
  input  logic [31:0] path_start_z_i,
  input  logic [31:0] path_end_x_i,
  input  logic [31:0] path_end_y_i,
  input  logic [31:0] path_end_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] fence_near_x_o,
  output logic [31:0] fence_near_y_o,
  output logic [31:0] path_near_x_o,
  output logic [31:0] path_near_y_o,
  output logic [31:0] closest_distance_o,
  output logic [1:0]  clamp_code_o
);

  typedef struct packed {
    coord_t [2:0] ap;
    coord_t [2:0] cp;
    diff_t  [2:0] u;
    diff_t  [2:0] v;
  } geo_t;

  typedef struct packed {
    dot_t a;
    dot_t b;
    dot_t c;
    dot_t d;
    dot_t e;
  } dots_t;

  typedef struct packed {
    coord_t ix;
    coord_t iy;
    coord_t jx;
    coord_t jy;
  } pts_t;

  typedef logic signed [34:0] pt_t;

  function automatic diff_t dext(coord_t x);
    return {x[31], x};
  endfunction

  function automatic dot_t sum3(prod_t x, prod_t y, prod_t z);
    return {{2{x[65]}}, x} + {{2{y[65]}}, y} + {{2{z[65]}}, z};
  endfunction

  function automatic wide_t wext(dot_t x);
    return {{68{x[67]}}, x};
  endfunction

  logic         en;
  logic [LAT:1] vld_q;

  coord_t a_pt [3], b_pt [3], c_pt [3], s_pt [3];
  geo_t   geo_d;
  geo_t   geo_q [1:ST_ALONG-1];
  diff_t  w_q [3];
  prod_t  uu_q [3], uv_q [3], vv_q [3], uw_q [3], vw_q [3];
  dots_t  dots_q [3:8];
  wide_t  ac, bb, be, cd, ae, bd;
  wide_t  den6_q, sn6_q, tn6_q;
  wide_t  sn7_d, sd7_d, tn7_d, td7_d, sn7_q, sd7_q, tn7_q, td7_q;
  wide_t  sn8_q, sd8_q, tn8_d, td8_q, tn8_q, nd8_d, nd8_q;
  clamp_e code8_d;
  wide_t  sn9_d, sd9_d, sn9_q, sd9_q, tn9_q, td9_q;
  clamp_e code_q [ST_CODE:LAT];
  prm_t   sc, tc;

  logic [62:0] pi_q [3], pj_q [3];
  logic        ineg_q [3], jneg_q [3];
  coord_t      ap_q [3], cp_q [3];
  pt_t         ipt_q [3], jpt_q [3];
  pts_t        pts_d;
  pts_t        pts_q [ST_PTS:LAT];
  logic [31:0] mag_q [3];
  logic [63:0] sq_q [3];
  logic [65:0] sum;
  logic [63:0] sx_q [0:SQRT_STEPS-1];
  logic [63:0] sr_q [0:SQRT_STEPS];
  logic        so_q [0:SQRT_STEPS];

  assign en          = !vld_q[LAT] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-1:1], in_valid_i};
    end
  end

  assign a_pt[0] = fence_start_x_i;
  assign a_pt[1] = fence_start_y_i;
  assign a_pt[2] = fence_start_z_i;
  assign b_pt[0] = fence_end_x_i;
  assign b_pt[1] = fence_end_y_i;
  assign b_pt[2] = fence_end_z_i;
  assign c_pt[0] = path_start_x_i;
  assign c_pt[1] = path_start_y_i;
  assign c_pt[2] = path_start_z_i;
  assign s_pt[0] = path_end_x_i;
  assign s_pt[1] = path_end_y_i;
  assign s_pt[2] = path_end_z_i;

  // stage 1: differences
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      geo_d.ap[k] = a_pt[k];
      geo_d.cp[k] = c_pt[k];
      geo_d.u[k]  = dext(s_pt[k]) - dext(c_pt[k]);
      geo_d.v[k]  = dext(b_pt[k]) - dext(a_pt[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      geo_q[1] <= geo_d;
      for (int i = 2; i < ST_ALONG; i++) begin
        geo_q[i] <= geo_q[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        w_q[k] <= dext(c_pt[k]) - dext(a_pt[k]);
      end
    end
  end

  // stage 2: coordinate products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        uu_q[k] <= $signed(geo_q[1].u[k]) * $signed(geo_q[1].u[k]);
        uv_q[k] <= $signed(geo_q[1].u[k]) * $signed(geo_q[1].v[k]);
        vv_q[k] <= $signed(geo_q[1].v[k]) * $signed(geo_q[1].v[k]);
        uw_q[k] <= $signed(geo_q[1].u[k]) * $signed(w_q[k]);
        vw_q[k] <= $signed(geo_q[1].v[k]) * $signed(w_q[k]);
      end
    end
  end

  // stage 3: dot products, then carried along
  always_ff @(posedge clk_i) begin
    if (en) begin
      dots_q[3].a <= sum3(uu_q[0], uu_q[1], uu_q[2]);
      dots_q[3].b <= sum3(uv_q[0], uv_q[1], uv_q[2]);
      dots_q[3].c <= sum3(vv_q[0], vv_q[1], vv_q[2]);
      dots_q[3].d <= sum3(uw_q[0], uw_q[1], uw_q[2]);
      dots_q[3].e <= sum3(vw_q[0], vw_q[1], vw_q[2]);
      for (int i = 4; i <= 8; i++) begin
        dots_q[i] <= dots_q[i-1];
      end
    end
  end

  // stages 4 and 5: wide products
  scd_mul u_mul_ac (.clk_i, .en_i(en), .a_i(dots_q[3].a), .b_i(dots_q[3].c), .p_o(ac));
  scd_mul u_mul_bb (.clk_i, .en_i(en), .a_i(dots_q[3].b), .b_i(dots_q[3].b), .p_o(bb));
  scd_mul u_mul_be (.clk_i, .en_i(en), .a_i(dots_q[3].b), .b_i(dots_q[3].e), .p_o(be));
  scd_mul u_mul_cd (.clk_i, .en_i(en), .a_i(dots_q[3].c), .b_i(dots_q[3].d), .p_o(cd));
  scd_mul u_mul_ae (.clk_i, .en_i(en), .a_i(dots_q[3].a), .b_i(dots_q[3].e), .p_o(ae));
  scd_mul u_mul_bd (.clk_i, .en_i(en), .a_i(dots_q[3].b), .b_i(dots_q[3].d), .p_o(bd));

  // stage 6: determinant and raw numerators
  always_ff @(posedge clk_i) begin
    if (en) begin
      den6_q <= ac - bb;
      sn6_q  <= be - cd;
      tn6_q  <= ae - bd;
    end
  end

  // stage 7: parallel case and path parameter edges
  always_comb begin
    if (den6_q[135] || den6_q == '0) begin
      sn7_d = '0;
      sd7_d = wide_t'(1);
      tn7_d = wext(dots_q[6].e);
      td7_d = wext(dots_q[6].c);
    end else begin
      sd7_d = den6_q;
      td7_d = den6_q;
      sn7_d = sn6_q;
      tn7_d = tn6_q;
      if (sn6_q[135]) begin
        sn7_d = '0;
        tn7_d = wext(dots_q[6].e);
        td7_d = wext(dots_q[6].c);
      end else if (sn6_q > den6_q) begin
        sn7_d = den6_q;
        tn7_d = wext(dots_q[6].e) + wext(dots_q[6].b);
        td7_d = wext(dots_q[6].c);
      end
    end
  end

  // stage 8: fence parameter clamp
  always_comb begin
    code8_d = CLAMP_NONE;
    nd8_d   = '0;
    tn8_d   = tn7_q;
    if (tn7_q[135]) begin
      code8_d = CLAMP_START;
      tn8_d   = '0;
      nd8_d   = -wext(dots_q[7].d);
    end else if (tn7_q > td7_q) begin
      code8_d = CLAMP_END;
      tn8_d   = td7_q;
      nd8_d   = wext(dots_q[7].b) - wext(dots_q[7].d);
    end
  end

  // stage 9: path parameter redone after a fence clamp
  always_comb begin
    sn9_d = sn8_q;
    sd9_d = sd8_q;
    if (code_q[ST_CODE] != CLAMP_NONE) begin
      if (nd8_q[135]) begin
        sn9_d = '0;
      end else if (nd8_q > wext(dots_q[8].a)) begin
        sn9_d = sd8_q;
      end else begin
        sn9_d = nd8_q;
        sd9_d = wext(dots_q[8].a);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn7_q <= sn7_d;
      sd7_q <= sd7_d;
      tn7_q <= tn7_d;
      td7_q <= td7_d;
      sn8_q <= sn7_q;
      sd8_q <= sd7_q;
      tn8_q <= tn8_d;
      td8_q <= td7_q;
      nd8_q <= nd8_d;
      code_q[ST_CODE] <= code8_d;
      for (int i = ST_CODE + 1; i <= LAT; i++) begin
        code_q[i] <= code_q[i-1];
      end
      sn9_q <= sn9_d;
      sd9_q <= sd9_d;
      tn9_q <= tn8_q;
      td9_q <= td8_q;
    end
  end

  // stages 10 to 40: parameter division
  scd_div u_div_s (.clk_i, .en_i(en), .n_i(sn9_q), .dn_i(sd9_q), .q_o(sc));
  scd_div u_div_t (.clk_i, .en_i(en), .n_i(tn9_q), .dn_i(td9_q), .q_o(tc));

  // stage 41: parameter times segment direction
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [32:0] vm, um;
        vm = geo_q[ST_ALONG-1].v[k][32] ? 33'(-geo_q[ST_ALONG-1].v[k])
                                         : geo_q[ST_ALONG-1].v[k];
        um = geo_q[ST_ALONG-1].u[k][32] ? 33'(-geo_q[ST_ALONG-1].u[k])
                                         : geo_q[ST_ALONG-1].u[k];
        pi_q[k]   <= tc * vm[31:0];
        pj_q[k]   <= sc * um[31:0];
        ineg_q[k] <= geo_q[ST_ALONG-1].v[k][32];
        jneg_q[k] <= geo_q[ST_ALONG-1].u[k][32];
        ap_q[k]   <= geo_q[ST_ALONG-1].ap[k];
        cp_q[k]   <= geo_q[ST_ALONG-1].cp[k];
      end
    end
  end

  // stage 42: rounded offsets, half away from zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [63:0] ti, tj;
        pt_t         ib, jb, io, jo;
        ti = {1'b0, pi_q[k]} + (64'd1 << (PFRAC - 1));
        tj = {1'b0, pj_q[k]} + (64'd1 << (PFRAC - 1));
        ib = {{3{ap_q[k][31]}}, ap_q[k]};
        jb = {{3{cp_q[k][31]}}, cp_q[k]};
        io = {2'b00, ti[62:30]};
        jo = {2'b00, tj[62:30]};
        ipt_q[k] <= ineg_q[k] ? ib - io : ib + io;
        jpt_q[k] <= jneg_q[k] ? jb - jo : jb + jo;
      end
    end
  end

  assign pts_d.ix = ipt_q[0][31:0];
  assign pts_d.iy = ipt_q[1][31:0];
  assign pts_d.jx = jpt_q[0][31:0];
  assign pts_d.jy = jpt_q[1][31:0];

  // stages 43 to 45: squared distance
  assign sum = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      pts_q[ST_PTS] <= pts_d;
      for (int i = ST_PTS + 1; i <= LAT; i++) begin
        pts_q[i] <= pts_q[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        logic signed [35:0] dp;
        logic [35:0]        dm;
        dp = {jpt_q[k][34], jpt_q[k]} - {ipt_q[k][34], ipt_q[k]};
        dm = dp[35] ? 36'(-dp) : dp;
        mag_q[k] <= dm[31:0];
        sq_q[k]  <= mag_q[k] * mag_q[k];
      end
      sx_q[0] <= sum[63:0];
      sr_q[0] <= '0;
      so_q[0] <= |sum[65:64];
    end
  end

  // stages 46 to 77: square root, two bits of radicand per step
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] ONE = 64'd1 << (62 - 2 * i);
    logic [64:0] trial;
    logic        take;
    assign trial = {1'b0, sr_q[i]} + {1'b0, ONE};
    assign take  = {1'b0, sx_q[i]} >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_q[i+1] <= take ? (sr_q[i] >> 1) + ONE : sr_q[i] >> 1;
        so_q[i+1] <= so_q[i];
      end
    end
    if (i < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          sx_q[i+1] <= take ? sx_q[i] - trial[63:0] : sx_q[i];
        end
      end
    end
  end

  assign fence_near_x_o     = pts_q[LAT].ix;
  assign fence_near_y_o     = pts_q[LAT].iy;
  assign path_near_x_o      = pts_q[LAT].jx;
  assign path_near_y_o      = pts_q[LAT].jy;
  assign closest_distance_o = so_q[SQRT_STEPS] ? '1 : sr_q[SQRT_STEPS][31:0];
  assign clamp_code_o       = code_q[LAT];

endmodule
